@@ sv/u2a_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the code point map for the UTF-8 to ASCII sanitiser.
package u2a_pkg;

  // Output buffer size; a piece stops starting characters at BUFFER_BYTES-4
  localparam int BUFFER_BYTES = 80;
  localparam int CHAR_LIMIT   = BUFFER_BYTES - 4;
  // Count never exceeds BUFFER_BYTES-2
  localparam int CNT_W        = $clog2(BUFFER_BYTES - 1);

  // Decode phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_TWO     = 2'd1;
  localparam logic [1:0] PH_THREE_A = 2'd2;
  localparam logic [1:0] PH_THREE_B = 2'd3;

  // Job kinds passed from front to back
  localparam logic [1:0] JOB_NONE = 2'd0;
  localparam logic [1:0] JOB_CHAR = 2'd1;
  localparam logic [1:0] JOB_DOTS = 2'd2;
  localparam logic [1:0] JOB_MARK = 2'd3;

  // Index of the final dot of an ellipsis
  localparam logic [1:0] DOTS_LAST = 2'd2;

  // Job queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [6:0] CH_QUOTE  = 7'h27;
  localparam logic [6:0] CH_DQUOTE = 7'h22;
  localparam logic [6:0] CH_DASH   = 7'h2D;
  localparam logic [6:0] CH_DOT    = 7'h2E;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] ch;
    logic       last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] ch;
  } map_t;

  // Map a decoded code point onto its ASCII replacement
  function automatic map_t map_cp(input logic [15:0] cp);
    map_t m;
    m.kind = JOB_NONE;
    m.ch   = 7'd0;
    unique case (cp)
      16'h2018, 16'h2019: begin
        m.kind = JOB_CHAR;
        m.ch   = CH_QUOTE;
      end
      16'h201C, 16'h201D: begin
        m.kind = JOB_CHAR;
        m.ch   = CH_DQUOTE;
      end
      16'h2013, 16'h2014: begin
        m.kind = JOB_CHAR;
        m.ch   = CH_DASH;
      end
      16'h2026: begin
        m.kind = JOB_DOTS;
        m.ch   = CH_DOT;
      end
      default: begin
        m.kind = JOB_NONE;
        m.ch   = 7'd0;
      end
    endcase
    return m;
  endfunction

endpackage

@@ sv/utf8_to_ascii_sanitizer_core.sv @@
`timescale 1ns / 1ps
// Top level of the UTF-8 to ASCII sanitiser: front, job queue and back end.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+----------------------------------------------
//   in_     | in_valid / in_stall   | in_text_byte[7:0], in_piece_end
//   out_    | out_valid / out_stall | out_ascii_char[6:0], out_has_char, out_chunk_end
//
// One input word is taken per cycle while the four-entry job queue has room.
// Each result word is built from the job at the queue head and held in the output
// register; an ellipsis stays at the queue head until its three dots have been sent.
// A job passes through the job queue and then the output register. Reset is synchronous,
// active low, and empties the queue and the output register.
// in_stall is raised only when the queue is full; out_stall holds the result.
module utf8_to_ascii_sanitizer_core import u2a_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_piece_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_ascii_char,
  output logic       out_has_char,
  output logic       out_chunk_end
);

  logic      push;
  logic      pop;
  job_t      job;
  job_t      head;
  q_status_t q_status;

  assign in_stall = q_status.full;

  // Decode input words into jobs
  u2a_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .q_full    (q_status.full),
    .text_byte (in_text_byte),
    .piece_end (in_piece_end),
    .push      (push),
    .job       (job)
  );

  // Buffer jobs between the two halves
  u2a_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (job),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  // Expand jobs into result words
  u2a_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .status     (q_status),
    .out_stall  (out_stall),
    .pop        (pop),
    .out_valid  (out_valid),
    .ascii_char (out_ascii_char),
    .has_char   (out_has_char),
    .chunk_end  (out_chunk_end)
  );

`ifndef ASSERT_OFF
  // A bare marker word is always an end with a zero character
  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_char) |-> (out_chunk_end && (out_ascii_char == 7'd0)))
    else $error("bare marker without chunk_end or with nonzero character");

  // A character word never carries a zero character
  a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_char) |-> (out_ascii_char != 7'd0))
    else $error("character word with zero character");

  // The queue cannot be both full and empty
  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("job queue reports full and empty together");

  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

@@ sv/u2a_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input words, runs the UTF-8 decoder and emits jobs.
module u2a_front import u2a_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       q_full,
  input  logic [7:0] text_byte,
  input  logic       piece_end,
  output logic       push,
  output job_t       job
);

  logic [1:0]       phase_r, phase_nxt;
  logic [9:0]       part_r, part_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_sum;
  logic             accept;
  logic             handled;
  logic             printable;
  logic [15:0]      cp;
  map_t             mapped;
  logic [1:0]       nchars;

  assign accept    = in_valid && !q_full;
  assign cp        = {part_r, text_byte[5:0]};
  assign mapped    = map_cp(cp);
  assign printable = (text_byte == 8'd10) || (text_byte == 8'd9) ||
                     ((text_byte >= 8'd32) && (text_byte < 8'd127));

  // Decode one word and work out the job it causes
  always_comb begin
    phase_nxt = phase_r;
    part_nxt  = part_r;
    handled   = 1'b0;
    job.kind  = JOB_NONE;
    job.ch    = 7'd0;
    job.last  = 1'b0;
    if (cnt_r < CNT_W'(CHAR_LIMIT)) begin
      if (phase_r != PH_IDLE) begin
        if (text_byte[7:6] == 2'b10) begin
          handled = 1'b1;
          if (phase_r == PH_THREE_A) begin
            part_nxt  = {part_r[3:0], text_byte[5:0]};
            phase_nxt = PH_THREE_B;
          end else begin
            part_nxt  = 10'd0;
            phase_nxt = PH_IDLE;
            job.kind  = mapped.kind;
            job.ch    = mapped.ch;
          end
        end else begin
          // Broken sequence: drop the lead, treat the word as fresh
          part_nxt  = 10'd0;
          phase_nxt = PH_IDLE;
        end
      end
      if (!handled) begin
        priority if (printable) begin
          job.kind = JOB_CHAR;
          job.ch   = text_byte[6:0];
        end else if (text_byte[7:5] == 3'b110) begin
          part_nxt  = {5'd0, text_byte[4:0]};
          phase_nxt = PH_TWO;
        end else if (text_byte[7:4] == 4'b1110) begin
          part_nxt  = {6'd0, text_byte[3:0]};
          phase_nxt = PH_THREE_A;
        end else begin
          part_nxt  = part_nxt;
        end
      end
    end

    unique case (job.kind)
      JOB_CHAR: nchars = 2'd1;
      JOB_DOTS: nchars = 2'd3;
      default:  nchars = 2'd0;
    endcase
    cnt_sum = cnt_r + CNT_W'(nchars);
    cnt_nxt = cnt_sum;

    // End of piece: mark the end if the piece holds any characters and return to reset state
    if (piece_end) begin
      if (cnt_sum != '0) begin
        job.last = 1'b1;
        if (job.kind == JOB_NONE) begin
          job.kind = JOB_MARK;
          job.ch   = 7'd0;
        end
      end
      phase_nxt = PH_IDLE;
      part_nxt  = 10'd0;
      cnt_nxt   = '0;
    end
  end

  assign push = accept && (job.kind != JOB_NONE);

  // Advance decoder state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      part_r  <= 10'd0;
      cnt_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      part_r  <= part_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ sv/u2a_queue.sv @@
`timescale 1ns / 1ps
// Short job queue between the decoder front and the output back end.
module u2a_queue import u2a_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      wr_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t status
);

  job_t           store_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r;
  logic           do_push, do_pop;

  assign status.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = store_r[rd_ptr_r];

  // Write entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wr_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ sv/u2a_back.sv @@
`timescale 1ns / 1ps
// Back end: expands queued jobs into result words through an output register.
module u2a_back import u2a_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head,
  input  q_status_t  status,
  input  logic       out_stall,
  output logic       pop,
  output logic       out_valid,
  output logic [6:0] ascii_char,
  output logic       has_char,
  output logic       chunk_end
);

  logic       valid_r, valid_nxt;
  logic [6:0] ch_r, ch_nxt;
  logic       has_r, has_nxt;
  logic       end_r, end_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic       load;
  logic       fin;

  assign load = !valid_r || !out_stall;
  assign fin  = (head.kind != JOB_DOTS) || (sub_r == DOTS_LAST);

  // Build the next result word from the queue head
  always_comb begin
    valid_nxt = valid_r;
    ch_nxt    = ch_r;
    has_nxt   = has_r;
    end_nxt   = end_r;
    sub_nxt   = sub_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = !status.empty;
      if (!status.empty) begin
        unique case (head.kind)
          JOB_MARK: ch_nxt = 7'd0;
          JOB_DOTS: ch_nxt = CH_DOT;
          default:  ch_nxt = head.ch;
        endcase
        has_nxt = (head.kind != JOB_MARK);
        end_nxt = head.last && fin;
        pop     = fin;
        sub_nxt = fin ? 2'd0 : sub_r + 2'd1;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r  <= ch_nxt;
    has_r <= has_nxt;
    end_r <= end_nxt;
  end

  assign out_valid  = valid_r;
  assign ascii_char = ch_r;
  assign has_char   = has_r;
  assign chunk_end  = end_r;

endmodule
